>>> rtl/afr_pkg.sv
package afr_pkg;

    localparam int MAX_FRAME = 64;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_ACK     = 3'd1;
    localparam logic [2:0] ERR_SUM     = 3'd2;
    localparam logic [2:0] ERR_LENGTH  = 3'd3;
    localparam logic [2:0] ERR_TIMEOUT = 3'd4;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [7:0] ACK_BYTE0 = 8'h01;
    localparam logic [7:0] ACK_BYTE1 = 8'hE0;
    localparam logic [7:0] ACK_BYTE2 = 8'hE1;

    localparam logic [0:0] CFG_ACK_TIMEOUT  = 1'd0;
    localparam logic [0:0] CFG_RESP_TIMEOUT = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic       want_message;
        logic [7:0] rx_byte;
    } in_word_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [5:0] index;
        logic       ok;
        logic [2:0] error_code;
    } out_word_t;

    typedef struct packed {
        logic [15:0] ack_timeout_ticks;
        logic [15:0] resp_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic      valid;
        out_word_t word;
    } result_t;

endpackage

>>> rtl/afr_cfg_regs.sv
module afr_cfg_regs
    import afr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_timeout_ticks  <= TIMEOUT_RESET;
            cfg_reg.resp_timeout_ticks <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACK_TIMEOUT:  cfg_reg.ack_timeout_ticks  <= cfg_data;
                CFG_RESP_TIMEOUT: cfg_reg.resp_timeout_ticks <= cfg_data;
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/afr_parser.sv
module afr_parser
    import afr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  in_word_t word,
    input  cfg_t     cfg,
    output result_t  res
);

    localparam int CW = $clog2(MAX_FRAME);
    localparam logic [8:0] MaxLen = 9'(MAX_FRAME - 2);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ACK0,
        PH_ACK1,
        PH_ACK2,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        mode_reg, mode_next;
    logic        ack_bad_reg, ack_bad_next;
    logic [CW-1:0] length_reg, length_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [15:0] limit;
    logic        waiting;
    logic [7:0]  b;

    assign b     = word.rx_byte;
    assign limit = mode_reg ? cfg.resp_timeout_ticks : cfg.ack_timeout_ticks;

    always_comb
    begin
        phase_next   = phase_reg;
        mode_next    = mode_reg;
        ack_bad_next = ack_bad_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        ticks_next   = ticks_reg;
        waiting      = 1'b0;
        res          = '0;

        case (op_t'(word.operation))
            OP_START:
            begin
                mode_next    = word.want_message;
                phase_next   = PH_ACK0;
                ack_bad_next = 1'b0;
                length_next  = '0;
                count_next   = '0;
                sum_next     = '0;
                ticks_next   = '0;
            end
            OP_TICK:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (ticks_reg != TICKS_MAX)
                        ticks_next = ticks_reg + 16'd1;
                    waiting = (phase_reg == PH_ACK0) || (phase_reg == PH_LEN && mode_reg);
                    if (waiting && ticks_next > limit)
                    begin
                        phase_next           = PH_IDLE;
                        res.valid            = 1'b1;
                        res.word.kind        = KIND_END;
                        res.word.error_code  = ERR_TIMEOUT;
                    end
                end
            end
            OP_BYTE:
            begin
                unique case (phase_reg)
                    PH_ACK0:
                    begin
                        if (b != ACK_BYTE0)
                            ack_bad_next = 1'b1;
                        phase_next = PH_ACK1;
                    end
                    PH_ACK1:
                    begin
                        if (b != ACK_BYTE1)
                            ack_bad_next = 1'b1;
                        phase_next = PH_ACK2;
                    end
                    PH_ACK2:
                    begin
                        if (b != ACK_BYTE2)
                            ack_bad_next = 1'b1;
                        if (!mode_reg)
                        begin
                            phase_next          = PH_IDLE;
                            res.valid           = 1'b1;
                            res.word.kind       = KIND_END;
                            res.word.data       = b;
                            res.word.ok         = !ack_bad_next;
                            res.word.error_code = ack_bad_next ? ERR_ACK : ERR_NONE;
                        end
                        else
                            phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        res.valid     = 1'b1;
                        res.word.data = b;
                        if (b == 8'd0 || {1'b0, b} > MaxLen)
                        begin
                            phase_next          = PH_IDLE;
                            res.word.kind       = KIND_END;
                            res.word.error_code = ERR_LENGTH;
                        end
                        else
                        begin
                            length_next   = CW'(b);
                            sum_next      = b;
                            count_next    = CW'(1);
                            phase_next    = PH_BODY;
                            res.word.kind = KIND_BYTE;
                        end
                    end
                    PH_BODY:
                    begin
                        res.valid      = 1'b1;
                        res.word.data  = b;
                        res.word.index = 6'(count_reg);
                        if (count_reg <= length_reg)
                        begin
                            sum_next      = sum_reg + b;
                            count_next    = count_reg + CW'(1);
                            res.word.kind = KIND_BYTE;
                        end
                        else
                        begin
                            phase_next    = PH_IDLE;
                            res.word.kind = KIND_END;
                            if (ack_bad_reg)
                                res.word.error_code = ERR_ACK;
                            else if (sum_reg != b)
                                res.word.error_code = ERR_SUM;
                            else
                                res.word.error_code = ERR_NONE;
                            res.word.ok = (res.word.error_code == ERR_NONE);
                        end
                    end
                    default:
                    begin
                        // byte while idle: dropped
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (!fire)
            res.valid = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            mode_reg    <= 1'b0;
            ack_bad_reg <= 1'b0;
            length_reg  <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            ticks_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            mode_reg    <= mode_next;
            ack_bad_reg <= ack_bad_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            ticks_reg   <= ticks_next;
        end
    end

endmodule

>>> rtl/afr_out_stage.sv
module afr_out_stage
    import afr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  result_t   res,
    output logic      space,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    logic      out_valid_reg;
    out_word_t out_word_reg;

    assign space = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (space)
            out_valid_reg <= fire && res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (space && fire && res.valid)
            out_word_reg <= res.word;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> rtl/ack_and_response_frame_receiver.sv
// Reply receiver: acknowledge check plus length-prefixed message with additive checksum.
//
// Input channel in_valid/in_stall/in_word carries one word per start, received byte
// or time tick. Output channel out_valid/out_stall/out_word carries stored message
// bytes (kind 0, with buffer index) and one frame-end word per reply (kind 1, with
// ok and error code). Timeout registers are written through cfg_we/cfg_index/cfg_data,
// index 0 for the acknowledge-only timeout and 1 for the message-mode timeout.
//
// An accepted word sits in the input register and is parsed by combinational logic; its
// result, if any, enters the output register, raising out_valid, when there is space.
// Throughput: one word per cycle unless a result is stalled; parser logic is combinational.
// The input register keeps taking words while a result sits in the output register,
// as long as that result is not stalled.
// When out_stall holds a pending result, the word in the input register waits and
// in_stall rises until the output side frees up; nothing is dropped.
// Reset puts the parser idle, clears the counters and loads both timeouts with 100.
module ack_and_response_frame_receiver
    import afr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic     in_valid_reg;
    in_word_t in_word_reg;
    logic     space;
    logic     fire;
    cfg_t     cfg;
    result_t  res;

    assign fire     = in_valid_reg && space;
    assign in_stall = in_valid_reg && !space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= in_word;
    end

    afr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afr_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .word  (in_word_reg),
        .cfg   (cfg),
        .res   (res)
    );

    afr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res       (res),
        .space     (space),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

>>> rtl/afr_checker.sv
module afr_checker
    import afr_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // empty output side never back-pressures the input
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // a fresh result comes from a word accepted through the input register
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without accepted input");

    // verdict fields agree with kind
    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.ok == (out_word.kind == KIND_END
                                       && out_word.error_code == ERR_NONE))
                      && (out_word.kind == KIND_END || out_word.error_code == ERR_NONE))
        else $error("inconsistent ok and error code");

endmodule

bind ack_and_response_frame_receiver afr_checker u_afr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
